// ----- hw/rtl/cltok_pkg.sv -----
// ----------------------------------------------------------------------------
// cltok_pkg - shared types and constants of the command line tokenizer
// Result kind codes, parse phase encoding, character codes and bus widths.
// ----------------------------------------------------------------------------
package cltok_pkg;

	// result kind codes carried on the master tuser
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_NAME_CHAR  = 3'd0;
	localparam kind_t KIND_IDENT_CHAR = 3'd1;
	localparam kind_t KIND_NAME_DONE  = 3'd2;
	localparam kind_t KIND_IDENT_DONE = 3'd3;
	localparam kind_t KIND_NUM_DONE   = 3'd4;
	localparam kind_t KIND_SEP_ONLY   = 3'd5;

	// parse phase, one-hot
	typedef enum logic [7:0] {
		PH_START = 8'b0000_0001,
		PH_NAME  = 8'b0000_0010,
		PH_ARG   = 8'b0000_0100,
		PH_IDENT = 8'b0000_1000,
		PH_ZERO  = 8'b0001_0000,
		PH_OCT   = 8'b0010_0000,
		PH_DEC   = 8'b0100_0000,
		PH_HEX   = 8'b1000_0000
	} phase_t;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_SEMI  = 8'd59;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_LOW_X = 8'd120;
	localparam logic [7:0] CH_LOW_A = 8'd97;
	localparam logic [7:0] CH_LOW_Z = 8'd122;
	localparam logic [7:0] CH_UP_A  = 8'd65;
	localparam logic [7:0] CH_UP_Z  = 8'd90;
	localparam logic [7:0] CH_UNDER = 8'd95;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic [31:0] HEX_LETTER_OFS = 32'd55;

	// bus widths
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 56;
	localparam int unsigned KIND_W      = 3;

endpackage

// ----- hw/rtl/command_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// command_line_tokenizer - splits a command line into commands and arguments
// Takes one byte per transaction and reports name and identifier characters,
// finished names, identifiers and numbers, with argument and command indexes.
// ----------------------------------------------------------------------------
// Usage: a new byte is accepted in every cycle as long as the single result
// register is empty or being drained in that same cycle. The per-byte work is
// the parse phase register and the 32-bit accumulator update (shift-add by 8,
// 10 or 16 plus digit), both done between the input handshake and the result
// register. At most one result per byte; bytes that only advance the number or
// are ignored give none. Byte 0 or 10 ends the line like ';' and always gives
// a result with tlast set, after which all counters return to zero.
module command_line_tokenizer #(
	parameter int unsigned MAX_STRING_CHARS = 32,
	parameter int unsigned MAX_ARGUMENTS    = 16,
	parameter int unsigned MAX_COMMANDS     = 16
) (
	input  logic clk,
	input  logic arst_n,
	// input byte stream
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [cltok_pkg::IN_TDATA_W-1:0] s_tdata,  // [7:0] char_in
	// result stream
	output logic m_tvalid,
	input  logic m_tready,
	// [7:0] char_value, [12:8] char_position, [44:13] number_value,
	// [48:45] arg_index, [52:49] command_index, [53] command_done,
	// [54] overflow, [55] zero
	output logic [cltok_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [cltok_pkg::KIND_W-1:0] m_tuser,  // [2:0] kind
	output logic m_tlast  // line_done
);
	import cltok_pkg::*;

	localparam int unsigned SPW = $clog2(MAX_STRING_CHARS);
	localparam int unsigned AW  = $clog2(MAX_ARGUMENTS + 1);
	localparam int unsigned CW  = $clog2(MAX_COMMANDS + 1);

	// parser state
	phase_t phase_q, phase_d;
	logic [31:0] acc_q, acc_d;
	logic [SPW-1:0] spos_q, spos_d;
	logic [AW-1:0] arg_cnt_q, arg_cnt_d;
	logic [CW-1:0] cmd_cnt_q, cmd_cnt_d;

	// result register
	logic out_valid_q;
	kind_t kind_q;
	logic [7:0] char_q;
	logic [4:0] pos_q;
	logic [31:0] num_q;
	logic [3:0] arg_idx_q, cmd_idx_q;
	logic cmd_done_q, line_done_q, ovf_q;

	// combinational result
	logic emit;
	kind_t r_kind;
	logic [7:0] r_char;
	logic [4:0] r_pos;
	logic [31:0] r_num;
	logic [3:0] r_arg, r_cmd;
	logic r_cmd_done, r_ovf;

	logic in_fire, out_fire;
	logic [7:0] byte_in, b;
	logic line_end, alpha_ch, num_ch, is_sep;
	logic cmd_over, arg_over;
	logic [31:0] arg_idx_ext, cmd_idx_ext;
	logic [SPW-1:0] spos_cur;
	logic push_ovf;
	logic [31:0] push_pos_ext;
	logic [7:0] hex_b;
	logic [31:0] digit_val, acc_scaled, byte_ext;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = !out_valid_q || m_tready;

	// byte classification, line end folds onto ';'
	assign byte_in   = s_tdata[7:0];
	assign line_end  = (byte_in == CH_NUL) || (byte_in == CH_LF);
	assign b         = line_end ? CH_SEMI : byte_in;
	assign alpha_ch  = (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z)
		|| (b == CH_UNDER);
	assign num_ch    = (b >= CH_ZERO) && (b <= CH_NINE);
	assign is_sep    = (b == CH_SPACE) || (b == CH_SEMI);
	assign byte_ext  = {24'd0, b};

	// saturated indexes
	assign cmd_over    = 32'(cmd_cnt_q) >= MAX_COMMANDS;
	assign arg_over    = 32'(arg_cnt_q) >= MAX_ARGUMENTS;
	assign cmd_idx_ext = cmd_over ? 32'(MAX_COMMANDS - 1) : 32'(cmd_cnt_q);
	assign arg_idx_ext = arg_over ? 32'(MAX_ARGUMENTS - 1) : 32'(arg_cnt_q);

	// string character push, a new string starts at position zero
	assign spos_cur     = (phase_q == PH_START || phase_q == PH_ARG) ? '0 : spos_q;
	assign push_ovf     = 32'(spos_cur) >= MAX_STRING_CHARS - 1;
	assign push_pos_ext = push_ovf ? 32'(MAX_STRING_CHARS - 1) : 32'(spos_cur);

	// digit value and scaled accumulator, case folding only in hex
	always_comb begin
		hex_b = (phase_q == PH_HEX && b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_OFS : b;
		if (phase_q == PH_HEX && hex_b > CH_NINE) begin
			digit_val = {24'd0, hex_b} - HEX_LETTER_OFS;
		end else begin
			digit_val = {24'd0, hex_b} - {24'd0, CH_ZERO};
		end
		case (phase_q)
			PH_OCT:  acc_scaled = {acc_q[28:0], 3'd0};
			PH_HEX:  acc_scaled = {acc_q[27:0], 4'd0};
			default: acc_scaled = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'd0};
		endcase
	end

	// per-byte parse step
	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		spos_d     = spos_q;
		arg_cnt_d  = arg_cnt_q;
		cmd_cnt_d  = cmd_cnt_q;
		emit       = 1'b0;
		r_kind     = KIND_NAME_CHAR;
		r_char     = '0;
		r_pos      = '0;
		r_num      = '0;
		r_arg      = '0;
		r_cmd      = cmd_idx_ext[3:0];
		r_cmd_done = 1'b0;
		r_ovf      = 1'b0;

		unique case (phase_q)
			PH_START: begin
				if (alpha_ch) begin
					r_kind  = KIND_NAME_CHAR;
					r_char  = b;
					r_pos   = push_pos_ext[4:0];
					spos_d  = push_ovf ? spos_cur : spos_cur + 1'b1;
					r_ovf   = push_ovf || cmd_over;
					phase_d = PH_NAME;
					emit    = 1'b1;
				end else if (line_end) begin
					r_kind = KIND_SEP_ONLY;
					emit   = 1'b1;
				end
			end
			PH_NAME: begin
				if (alpha_ch || num_ch) begin
					r_kind = KIND_NAME_CHAR;
					r_char = b;
					r_pos  = push_pos_ext[4:0];
					spos_d = push_ovf ? spos_cur : spos_cur + 1'b1;
					r_ovf  = push_ovf || cmd_over;
					emit   = 1'b1;
				end else if (is_sep) begin
					r_kind    = KIND_NAME_DONE;
					r_ovf     = cmd_over;
					arg_cnt_d = '0;
					emit      = 1'b1;
					if (b == CH_SEMI) begin
						r_cmd_done = 1'b1;
						cmd_cnt_d  = cmd_over ? cmd_cnt_q : cmd_cnt_q + 1'b1;
						phase_d    = PH_START;
					end else begin
						phase_d = PH_ARG;
					end
				end
			end
			PH_ARG: begin
				if (b == CH_ZERO) begin
					acc_d   = '0;
					phase_d = PH_ZERO;
				end else if (num_ch) begin
					acc_d   = digit_val;
					phase_d = PH_DEC;
				end else if (b == CH_SEMI) begin
					r_kind     = KIND_SEP_ONLY;
					r_arg      = arg_idx_ext[3:0];
					r_ovf      = cmd_over;
					r_cmd_done = 1'b1;
					cmd_cnt_d  = cmd_over ? cmd_cnt_q : cmd_cnt_q + 1'b1;
					arg_cnt_d  = '0;
					phase_d    = PH_START;
					emit       = 1'b1;
				end else begin
					r_kind  = KIND_IDENT_CHAR;
					r_char  = b;
					r_pos   = push_pos_ext[4:0];
					r_arg   = arg_idx_ext[3:0];
					spos_d  = push_ovf ? spos_cur : spos_cur + 1'b1;
					r_ovf   = push_ovf || arg_over || cmd_over;
					phase_d = PH_IDENT;
					emit    = 1'b1;
				end
			end
			PH_IDENT, PH_ZERO, PH_OCT, PH_DEC, PH_HEX: begin
				if (is_sep) begin
					// finish the argument
					r_kind    = (phase_q == PH_IDENT) ? KIND_IDENT_DONE : KIND_NUM_DONE;
					r_num     = (phase_q == PH_IDENT) ? '0 : acc_q;
					r_arg     = arg_idx_ext[3:0];
					r_ovf     = arg_over || cmd_over;
					arg_cnt_d = arg_over ? arg_cnt_q : arg_cnt_q + 1'b1;
					emit      = 1'b1;
					if (b == CH_SEMI) begin
						r_cmd_done = 1'b1;
						cmd_cnt_d  = cmd_over ? cmd_cnt_q : cmd_cnt_q + 1'b1;
						arg_cnt_d  = '0;
						phase_d    = PH_START;
					end else begin
						phase_d = PH_ARG;
					end
				end else if (phase_q == PH_IDENT) begin
					r_kind = KIND_IDENT_CHAR;
					r_char = b;
					r_pos  = push_pos_ext[4:0];
					r_arg  = arg_idx_ext[3:0];
					spos_d = push_ovf ? spos_cur : spos_cur + 1'b1;
					r_ovf  = push_ovf || arg_over || cmd_over;
					emit   = 1'b1;
				end else if (phase_q == PH_ZERO) begin
					if (b == CH_LOW_X) begin
						phase_d = PH_HEX;
					end else begin
						acc_d   = byte_ext - {24'd0, CH_ZERO};
						phase_d = PH_OCT;
					end
				end else begin
					acc_d = acc_scaled + digit_val;
				end
			end
			default: begin
				phase_d = PH_START;
			end
		endcase

		// line end returns every counter to its reset value
		if (line_end) begin
			phase_d   = PH_START;
			acc_d     = '0;
			spos_d    = '0;
			arg_cnt_d = '0;
			cmd_cnt_d = '0;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			acc_q     <= '0;
			spos_q    <= '0;
			arg_cnt_q <= '0;
			cmd_cnt_q <= '0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			spos_q    <= spos_d;
			arg_cnt_q <= arg_cnt_d;
			cmd_cnt_q <= cmd_cnt_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			kind_q      <= r_kind;
			char_q      <= r_char;
			pos_q       <= r_pos;
			num_q       <= r_num;
			arg_idx_q   <= r_arg;
			cmd_idx_q   <= r_cmd;
			cmd_done_q  <= r_cmd_done;
			line_done_q <= line_end;
			ovf_q       <= r_ovf;
		end
	end

	// output packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = line_done_q;
	assign m_tdata  = {1'b0, ovf_q, cmd_done_q, cmd_idx_q, arg_idx_q, num_q, pos_q, char_q};

`ifndef SYNTHESIS
	// input is held back only while a result waits
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> out_valid_q)
		else $error("input stalled with empty result register");

	// a line end leaves the parser at its reset state
	a_line_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && line_end) |=> (phase_q == PH_START && arg_cnt_q == '0
			&& cmd_cnt_q == '0 && spos_q == '0 && acc_q == '0))
		else $error("parser state not cleared after line end");

	// character results never close a command or a line
	a_char_not_closing: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (kind_q == KIND_NAME_CHAR || kind_q == KIND_IDENT_CHAR))
			|-> (!cmd_done_q && !line_done_q))
		else $error("character result marked as closing");

	// a line end always yields a result
	a_line_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && line_end) |=> (out_valid_q && line_done_q))
		else $error("line end gave no result");

	// result kind stays within the defined codes
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (kind_q <= KIND_SEP_ONLY))
		else $error("undefined result kind");
`endif

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb - self-checking bench for the command line tokenizer
// Streams directed and random command lines into the byte input with bursty
// sending and a shifting receiver stall pattern. Every accepted byte runs
// through a local copy of the parser, and each result transaction is compared
// field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
module tb;
	import cltok_pkg::*;

	localparam int unsigned STR_MAX      = 32;
	localparam int unsigned ARG_MAX      = 16;
	localparam int unsigned CMD_MAX      = 16;
	localparam int unsigned RANDOM_BYTES = 1150;
	localparam int unsigned DRAIN_AT     = 600;
	localparam int unsigned SETTLE_CYC   = 8;
	localparam int unsigned IDLE_LIMIT   = 1000;

	// one predicted result of the tokenizer
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  chr;
		logic [4:0]  pos;
		logic [31:0] num;
		logic [3:0]  arg;
		logic [3:0]  cmd;
		logic        cmd_done;
		logic        line_done;
		logic        ovf;
	} token_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_PERIODIC,
		RX_COIN
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic m_tlast;

	// parser state of the predictor
	phase_t      tok_phase = PH_START;
	logic [31:0] tok_acc = '0;
	int unsigned tok_pos = 0;
	int unsigned tok_args = 0;
	int unsigned tok_cmds = 0;

	logic [7:0] line_bytes[$];
	token_t     pending_tokens[$];

	string name_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string name_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string hex_chars = "0123456789abcdefABCDEFgzGZ";

	int unsigned bytes_sent = 0;
	int unsigned results_checked = 0;
	int unsigned lines_seen = 0;
	int unsigned ovf_seen = 0;
	int unsigned mismatches = 0;
	int unsigned kind_seen[0:7];
	int unsigned idle_cycles = 0;

	// driver and monitor working variables
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	bit          draining = 1'b0;
	bit          got_token;
	token_t      next_tok;
	token_t      rx_want;
	rx_mode_t    rx_mode = RX_ALWAYS;
	int unsigned rx_mode_left = 0;
	int unsigned rx_cycle = 0;
	logic        rx_ready;

	command_line_tokenizer #(
		.MAX_STRING_CHARS(STR_MAX),
		.MAX_ARGUMENTS(ARG_MAX),
		.MAX_COMMANDS(CMD_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// character classes
	function automatic bit is_alpha(input logic [7:0] b);
		return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
			b == CH_UNDER;
	endfunction

	function automatic bit is_num(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	// saturated indexes as reported on the bus
	function automatic logic [3:0] cmd_slot();
		return 4'((tok_cmds >= CMD_MAX) ? CMD_MAX - 1 : tok_cmds);
	endfunction

	function automatic logic [3:0] arg_slot();
		return 4'((tok_args >= ARG_MAX) ? ARG_MAX - 1 : tok_args);
	endfunction

	// reports one string character, returns string overflow
	task automatic emit_char(inout token_t t, input kind_t k, input logic [7:0] b,
			output logic str_ovf);
		str_ovf = tok_pos >= STR_MAX - 1;
		t.kind = k;
		t.chr = b;
		t.pos = 5'(str_ovf ? STR_MAX - 1 : tok_pos);
		if (!str_ovf)
			tok_pos++;
	endtask

	task automatic close_cmd(inout token_t t);
		t.cmd_done = 1'b1;
		if (tok_cmds < CMD_MAX)
			tok_cmds++;
		tok_args = 0;
		tok_phase = PH_START;
	endtask

	// argument finished by space or semicolon
	task automatic end_arg(inout token_t t, input kind_t k, input logic [7:0] b);
		t.kind = k;
		t.arg = arg_slot();
		t.ovf = (tok_args >= ARG_MAX) || (tok_cmds >= CMD_MAX);
		if (k == KIND_NUM_DONE)
			t.num = tok_acc;
		if (tok_args < ARG_MAX)
			tok_args++;
		if (b == CH_SEMI)
			close_cmd(t);
		else
			tok_phase = PH_ARG;
	endtask

	// advances the predicted parser by one byte
	task automatic tokenize_byte(input logic [7:0] raw, output bit emit, output token_t t);
		logic [7:0]  b;
		logic [7:0]  hb;
		logic [31:0] digit;
		logic        so;
		bit          eol;
		b = raw;
		eol = (raw == CH_NUL) || (raw == CH_LF);
		emit = 1'b0;
		if (eol)
			b = CH_SEMI;
		t = '0;
		t.cmd = cmd_slot();
		case (tok_phase)
			PH_START: begin
				if (is_alpha(b)) begin
					tok_pos = 0;
					emit_char(t, KIND_NAME_CHAR, b, so);
					t.ovf = so || (tok_cmds >= CMD_MAX);
					tok_phase = PH_NAME;
					emit = 1'b1;
				end else if (eol) begin
					t.kind = KIND_SEP_ONLY;
					emit = 1'b1;
				end
			end
			PH_NAME: begin
				if (is_alpha(b) || is_num(b)) begin
					emit_char(t, KIND_NAME_CHAR, b, so);
					t.ovf = so || (tok_cmds >= CMD_MAX);
					emit = 1'b1;
				end else if (b == CH_SEMI) begin
					t.kind = KIND_NAME_DONE;
					t.ovf = tok_cmds >= CMD_MAX;
					close_cmd(t);
					emit = 1'b1;
				end else if (b == CH_SPACE) begin
					t.kind = KIND_NAME_DONE;
					t.ovf = tok_cmds >= CMD_MAX;
					tok_args = 0;
					tok_phase = PH_ARG;
					emit = 1'b1;
				end
			end
			PH_ARG: begin
				if (b == CH_ZERO) begin
					tok_acc = '0;
					tok_phase = PH_ZERO;
				end else if (is_num(b)) begin
					tok_acc = {24'd0, b} - {24'd0, CH_ZERO};
					tok_phase = PH_DEC;
				end else if (b == CH_SEMI) begin
					t.kind = KIND_SEP_ONLY;
					t.arg = arg_slot();
					t.ovf = tok_cmds >= CMD_MAX;
					close_cmd(t);
					emit = 1'b1;
				end else begin
					// anything else, a second space too, opens an identifier
					tok_pos = 0;
					t.arg = arg_slot();
					emit_char(t, KIND_IDENT_CHAR, b, so);
					t.ovf = so || (tok_args >= ARG_MAX) || (tok_cmds >= CMD_MAX);
					tok_phase = PH_IDENT;
					emit = 1'b1;
				end
			end
			PH_IDENT: begin
				if (b == CH_SPACE || b == CH_SEMI) begin
					end_arg(t, KIND_IDENT_DONE, b);
				end else begin
					t.arg = arg_slot();
					emit_char(t, KIND_IDENT_CHAR, b, so);
					t.ovf = so || (tok_args >= ARG_MAX) || (tok_cmds >= CMD_MAX);
				end
				emit = 1'b1;
			end
			PH_ZERO: begin
				if (b == CH_LOW_X) begin
					tok_phase = PH_HEX;
				end else if (b == CH_SPACE || b == CH_SEMI) begin
					end_arg(t, KIND_NUM_DONE, b);
					emit = 1'b1;
				end else begin
					tok_acc = {24'd0, b} - {24'd0, CH_ZERO};
					tok_phase = PH_OCT;
				end
			end
			default: begin
				if (b == CH_SPACE || b == CH_SEMI) begin
					end_arg(t, KIND_NUM_DONE, b);
					emit = 1'b1;
				end else if (tok_phase == PH_HEX) begin
					// hex letters fold to upper case, any byte past nine is a letter digit
					hb = b;
					if (hb >= CH_LOW_A && hb <= CH_LOW_Z)
						hb = hb - CASE_OFS;
					digit = (hb > CH_NINE) ? {24'd0, hb} - HEX_LETTER_OFS :
						{24'd0, hb} - {24'd0, CH_ZERO};
					tok_acc = tok_acc * 16 + digit;
				end else begin
					digit = {24'd0, b} - {24'd0, CH_ZERO};
					tok_acc = tok_acc * ((tok_phase == PH_OCT) ? 8 : 10) + digit;
				end
			end
		endcase
		// line end clears all parser state
		if (eol) begin
			t.line_done = 1'b1;
			tok_phase = PH_START;
			tok_acc = '0;
			tok_pos = 0;
			tok_args = 0;
			tok_cmds = 0;
		end
	endtask

	// appends a name or an identifier of the given length
	task automatic push_str(input bit is_name, input int unsigned len);
		logic [7:0] ch;
		for (int unsigned i = 0; i < len; i++) begin
			if (is_name) begin
				ch = (i == 0) ? name_head[$urandom_range(0, name_head.len() - 1)] :
					name_body[$urandom_range(0, name_body.len() - 1)];
			end else begin
				do
					ch = 8'($urandom_range(1, 255));
				while (ch == CH_LF || ch == CH_SPACE || ch == CH_SEMI || (i == 0 && is_num(ch)));
			end
			line_bytes.push_back(ch);
		end
	endtask

	function automatic int unsigned pick_len(input int unsigned odds, input int unsigned lo,
			input int unsigned hi);
		return ($urandom_range(0, odds - 1) == 0) ? $urandom_range(STR_MAX - 2, STR_MAX + 2) :
			$urandom_range(lo, hi);
	endfunction

	// stimulus and end of run
	initial begin
		string       lead;
		int unsigned ncmd;
		int unsigned nargs;
		int unsigned ndig;
		int unsigned lead_len;
		lead = ";A_z9 0 0xfF 017 9 ;b  ";
		for (int i = 0; i < lead.len(); i++)
			line_bytes.push_back(lead[i]);
		// identifier opened by a second space, high byte, then line ends
		line_bytes.push_back(8'hFF);
		line_bytes.push_back(CH_LF);
		line_bytes.push_back(8'h7F);
		line_bytes.push_back(CH_NUL);
		lead_len = line_bytes.size();

		// random well-formed lines with some noise
		while (line_bytes.size() < lead_len + RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0)
				line_bytes.push_back(8'($urandom_range(0, 255)));
			ncmd = ($urandom_range(0, 39) == 0) ? $urandom_range(CMD_MAX + 1, CMD_MAX + 2) :
				$urandom_range(1, 3);
			for (int unsigned c = 0; c < ncmd; c++) begin
				if ($urandom_range(0, 11) == 0)
					line_bytes.push_back(CH_SEMI);
				push_str(1'b1, pick_len(40, 1, 6));
				nargs = ($urandom_range(0, 29) == 0) ? $urandom_range(ARG_MAX - 1, ARG_MAX + 2) :
					$urandom_range(0, 3);
				for (int unsigned a = 0; a < nargs; a++) begin
					line_bytes.push_back(CH_SPACE);
					case ($urandom_range(0, 5))
						0, 1: push_str(1'b0, pick_len(30, 1, 5));
						2: begin
							line_bytes.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
							ndig = $urandom_range(0, 11);
							repeat (ndig) line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
						end
						3: begin
							line_bytes.push_back(CH_ZERO);
							ndig = $urandom_range(1, 12);
							repeat (ndig) line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
						end
						4: begin
							line_bytes.push_back(CH_ZERO);
							line_bytes.push_back(CH_LOW_X);
							ndig = $urandom_range(0, 10);
							repeat (ndig)
								line_bytes.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
						end
						default: begin
							// a lone digit, or a digit followed by junk bytes
							line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
							if ($urandom_range(0, 1) == 0)
								push_str(1'b0, $urandom_range(1, 3));
						end
					endcase
				end
				if ($urandom_range(0, 5) == 0)
					line_bytes.push_back(CH_SPACE);
				if (c + 1 < ncmd)
					line_bytes.push_back(CH_SEMI);
				else
					line_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_NUL);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (line_bytes.size() != 0 || s_tvalid || pending_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("covered %0d input bytes, %0d results over %0d lines, %0d with overflow",
			bytes_sent, results_checked, lines_seen, ovf_seen);
		$display("kinds: %0d/%0d name/ident chars, %0d names, %0d idents, %0d numbers, %0d seps",
			kind_seen[KIND_NAME_CHAR], kind_seen[KIND_IDENT_CHAR], kind_seen[KIND_NAME_DONE],
			kind_seen[KIND_IDENT_DONE], kind_seen[KIND_NUM_DONE], kind_seen[KIND_SEP_ONLY]);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// byte driver: bursts with gaps, one pause until all results are out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				tokenize_byte(s_tdata, got_token, next_tok);
				if (got_token)
					pending_tokens.push_back(next_tok);
				bytes_sent++;
				if (bytes_sent == DRAIN_AT)
					draining = 1'b1;
			end
			if (draining && pending_tokens.size() == 0)
				draining = 1'b0;
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (line_bytes.size() == 0 || draining) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= line_bytes.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) :
							$urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
		end
	end

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d, %s: expected 0x%0h, got 0x%0h",
					results_checked, field, want, got);
		end
	endtask

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				kind_seen[m_tuser]++;
				if (m_tlast)
					lines_seen++;
				if (m_tdata[54])
					ovf_seen++;
				if (pending_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d of kind %0d arrived with none expected",
							results_checked, m_tuser);
				end else begin
					rx_want = pending_tokens.pop_front();
					check_field("kind", 32'(rx_want.kind), 32'(m_tuser));
					check_field("char_value", 32'(rx_want.chr), 32'(m_tdata[7:0]));
					check_field("char_position", 32'(rx_want.pos), 32'(m_tdata[12:8]));
					check_field("number_value", rx_want.num, m_tdata[44:13]);
					check_field("arg_index", 32'(rx_want.arg), 32'(m_tdata[48:45]));
					check_field("command_index", 32'(rx_want.cmd), 32'(m_tdata[52:49]));
					check_field("command_done", 32'(rx_want.cmd_done), 32'(m_tdata[53]));
					check_field("overflow", 32'(rx_want.ovf), 32'(m_tdata[54]));
					check_field("padding", 32'd0, 32'(m_tdata[55]));
					check_field("line_done", 32'(rx_want.line_done), 32'(m_tlast));
				end
				results_checked++;
			end
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(20, 150);
			end else begin
				rx_mode_left--;
			end
			rx_cycle++;
			case (rx_mode)
				RX_ALWAYS: rx_ready = 1'b1;
				RX_MOSTLY: rx_ready = $urandom_range(0, 3) != 0;
				RX_PERIODIC: rx_ready = (rx_cycle % 11) >= 6;
				default: rx_ready = 1'($urandom_range(0, 1));
			endcase
			m_tready <= rx_ready;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, pending_tokens.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
